>>> src/ssfr_pkg.sv
// Package for the sprite sheet frame rectangle block.
// Holds configuration register indexes, issue codes and port widths; no dependencies.
package ssfr_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int AGE_W      = 32;
  localparam int RATE_W     = 16;
  localparam int ISSUE_W    = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [ISSUE_W-1:0]   issue_t;

  localparam cfg_idx_t REG_GRID_COLUMNS = 4'd0;
  localparam cfg_idx_t REG_GRID_ROWS    = 4'd1;
  localparam cfg_idx_t REG_FRAME_COUNT  = 4'd2;
  localparam cfg_idx_t REG_START_FRAME  = 4'd3;
  localparam cfg_idx_t REG_FRAME_RATE   = 4'd4;
  localparam cfg_idx_t REG_MODE_BITS    = 4'd5;
  localparam cfg_idx_t REG_IMAGE_WIDTH  = 4'd6;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 4'd7;

  localparam issue_t ISSUE_OK          = 3'd0;
  localparam issue_t ISSUE_NO_IMAGE    = 3'd1;
  localparam issue_t ISSUE_COUNT_GRID  = 3'd2;
  localparam issue_t ISSUE_GRID_IMAGE  = 3'd3;
  localparam issue_t ISSUE_NOT_DIVIDES = 3'd4;

endpackage

>>> src/ssfr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a side payload and a valid bit alongside; no package dependencies.
module ssfr_div_pipe #(
  parameter int N = 8,
  parameter int D = 8,
  parameter int P = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  input  logic [P-1:0] payload,
  output logic         out_valid,
  output logic [N-1:0] quotient,
  output logic [D-1:0] remainder,
  output logic [P-1:0] out_payload
);

  logic [N-1:0] dq [0:N];
  logic [D-1:0] rm [0:N];
  logic [D-1:0] dv [0:N];
  logic [P-1:0] pl [0:N];
  logic         vl [0:N];

  assign dq[0] = dividend;
  assign rm[0] = '0;
  assign dv[0] = divisor;
  assign pl[0] = payload;
  assign vl[0] = in_valid;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [D:0] trial;
    logic [D:0] diff;
    logic       ge;
    assign trial = {rm[s], dq[s][N-1]};
    assign diff  = trial - {1'b0, dv[s]};
    assign ge    = trial >= {1'b0, dv[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else if (en) begin
        vl[s+1] <= vl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[s+1] <= ge ? diff[D-1:0] : trial[D-1:0];
        dq[s+1] <= {dq[s][N-2:0], ge};
        dv[s+1] <= dv[s];
        pl[s+1] <= pl[s];
      end
    end
  end

  assign out_valid   = vl[N];
  assign quotient    = dq[N];
  assign remainder   = rm[N];
  assign out_payload = pl[N];

endmodule

>>> src/sprite_sheet_frame_rect_core.sv
// Sprite sheet frame rectangle, top level.
// Depends on ssfr_pkg and ssfr_div_pipe.
//
// Input channel: in_valid, in_stall, age (signed Q16.16). Output channel:
// out_valid, out_stall and the result fields. An item moves at a clock edge
// where valid is high and stall is low. Each input item gives one result.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes one register per handshake; cfg_ready is always high and writes
// are expected only while no item is in flight.
// Throughput is one item per cycle while out_stall is low and no settle is
// under way. Most of the pipeline depth is in the two bit-per-stage dividers
// (frame modulo count, frame by columns). After each configuration write
// the input stalls while the cell size divider settles.
// Reset (synchronous, active high) loads the register defaults and empties
// the pipeline; the input is stalled for the settle time after reset too.
// When out_stall is high with a result waiting, the whole pipeline holds and
// in_stall is raised; nothing is dropped or repeated.
module sprite_sheet_frame_rect_core #(
  parameter int DIM_BITS   = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ssfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [ssfr_pkg::AGE_W-1:0] age,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [COUNT_BITS-1:0]            frame_index,
  output logic [DIM_BITS-1:0]              rect_x,
  output logic [DIM_BITS-1:0]              rect_y,
  output logic [DIM_BITS-1:0]              rect_w,
  output logic [DIM_BITS-1:0]              rect_h,
  output logic [ssfr_pkg::ISSUE_W-1:0]     issue_code,
  output logic [DIM_BITS-1:0]              cell_width,
  output logic [DIM_BITS-1:0]              cell_height,
  output logic [2*DIM_BITS-1:0]            grid_capacity
);

  localparam int D    = DIM_BITS;
  localparam int C    = COUNT_BITS;
  localparam int ADVW = ssfr_pkg::AGE_W - 1 + ssfr_pkg::RATE_W - 24;
  localparam int SW   = ((C > ADVW) ? C : ADVW) + 1;
  localparam int CAPW = 2 * D;
  localparam int EW   = (C > CAPW) ? C : CAPW;
  localparam int PW   = ssfr_pkg::AGE_W - 1 + ssfr_pkg::RATE_W;
  localparam int LAT  = D + 3;
  localparam int BW   = $clog2(LAT + 1);

  // Configuration registers.
  logic [D-1:0]  grid_columns_r, grid_rows_r, image_width_r, image_height_r;
  logic [C-1:0]  frame_count_r, start_frame_r;
  logic [ssfr_pkg::RATE_W-1:0] frame_rate_r;
  logic [1:0]    mode_r;
  logic [BW-1:0] busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns_r <= D'(1);
      grid_rows_r    <= D'(1);
      frame_count_r  <= C'(1);
      start_frame_r  <= '0;
      frame_rate_r   <= '0;
      mode_r         <= '0;
      image_width_r  <= '0;
      image_height_r <= '0;
      busy           <= BW'(LAT);
    end else if (cfg_valid && cfg_ready) begin
      busy <= BW'(LAT);
      case (cfg_index)
        ssfr_pkg::REG_GRID_COLUMNS: grid_columns_r <= cfg_data[D-1:0];
        ssfr_pkg::REG_GRID_ROWS:    grid_rows_r    <= cfg_data[D-1:0];
        ssfr_pkg::REG_FRAME_COUNT:  frame_count_r  <= cfg_data[C-1:0];
        ssfr_pkg::REG_START_FRAME:  start_frame_r  <= cfg_data[C-1:0];
        ssfr_pkg::REG_FRAME_RATE:   frame_rate_r   <= cfg_data[ssfr_pkg::RATE_W-1:0];
        ssfr_pkg::REG_MODE_BITS:    mode_r         <= cfg_data[1:0];
        ssfr_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[D-1:0];
        ssfr_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_data[D-1:0];
        default: ;
      endcase
    end else if (busy != '0) begin
      busy <= busy - BW'(1);
    end
  end

  assign cfg_ready = 1'b1;

  // Values derived from configuration, refreshed every cycle.
  logic [D-1:0]    cols_s, rows_s, qw_r, qh_r, remw_r, remh_r, fw_s, fh_s;
  logic [C-1:0]    cnt_s, cntm1_s, base_s;
  logic [CAPW-1:0] cap_s;
  logic            empty_s;
  ssfr_pkg::issue_t issue_s;
  logic [D-1:0]    cw_s, ch_s;
  logic            sdw_v, sdh_v, sdw_p, sdh_p;
  logic [D-1:0]    sdw_q, sdh_q, sdw_r, sdh_r;

  ssfr_div_pipe #(.N(D), .D(D), .P(1)) u_div_w (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(1'b1),
    .dividend(image_width_r), .divisor(cols_s), .payload(1'b1),
    .out_valid(sdw_v), .quotient(sdw_q), .remainder(sdw_r), .out_payload(sdw_p)
  );

  ssfr_div_pipe #(.N(D), .D(D), .P(1)) u_div_h (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(1'b1),
    .dividend(image_height_r), .divisor(rows_s), .payload(1'b1),
    .out_valid(sdh_v), .quotient(sdh_q), .remainder(sdh_r), .out_payload(sdh_p)
  );

  always_ff @(posedge clk) begin
    cols_s  <= (grid_columns_r == '0) ? D'(1) : grid_columns_r;
    rows_s  <= (grid_rows_r == '0) ? D'(1) : grid_rows_r;
    cnt_s   <= (frame_count_r == '0) ? C'(1) : frame_count_r;
    cntm1_s <= ((frame_count_r == '0) ? C'(1) : frame_count_r) - C'(1);
    base_s  <= (start_frame_r < cntm1_s) ? start_frame_r : cntm1_s;
    cap_s   <= CAPW'(cols_s) * CAPW'(rows_s);
    empty_s <= (image_width_r == '0) || (image_height_r == '0);
    if (sdw_v && sdw_p) begin
      qw_r   <= sdw_q;
      remw_r <= sdw_r;
    end
    if (sdh_v && sdh_p) begin
      qh_r   <= sdh_q;
      remh_r <= sdh_r;
    end
    fw_s <= (qw_r == '0) ? D'(1) : qw_r;
    fh_s <= (qh_r == '0) ? D'(1) : qh_r;
  end

  always_ff @(posedge clk) begin
    cw_s    <= '0;
    ch_s    <= '0;
    issue_s <= ssfr_pkg::ISSUE_OK;
    if (!mode_r[0] && (frame_count_r <= C'(1))) begin
      cw_s <= image_width_r;
      ch_s <= image_height_r;
    end else if (empty_s) begin
      issue_s <= ssfr_pkg::ISSUE_NO_IMAGE;
    end else if (EW'(cnt_s) > EW'(cap_s)) begin
      issue_s <= ssfr_pkg::ISSUE_COUNT_GRID;
    end else if ((cols_s > image_width_r) || (rows_s > image_height_r)) begin
      issue_s <= ssfr_pkg::ISSUE_GRID_IMAGE;
    end else if ((remw_r != '0) || (remh_r != '0)) begin
      issue_s <= ssfr_pkg::ISSUE_NOT_DIVIDES;
    end else begin
      cw_s <= qw_r;
      ch_s <= qh_r;
    end
  end

  // Item pipeline.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = (busy != '0) || !en;

  logic                                  v1, v2, v3, v4, v5;
  logic [ssfr_pkg::AGE_W-2:0]            age_pos;
  logic [PW-1:0]                         prod;
  logic [SW-1:0]                         sum3;
  logic [C-1:0]                          hold3;
  logic                                  wrap3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid && (busy == '0);
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      age_pos <= age[ssfr_pkg::AGE_W-1] ? '0 : age[ssfr_pkg::AGE_W-2:0];
      prod    <= PW'(age_pos) * PW'(frame_rate_r);
      if (mode_r[0]) begin
        sum3 <= SW'(base_s) + SW'(prod[PW-1:24]);
        hold3 <= ((SW'(base_s) + SW'(prod[PW-1:24])) < SW'(cntm1_s))
                 ? C'(SW'(base_s) + SW'(prod[PW-1:24])) : cntm1_s;
      end else begin
        sum3  <= SW'(base_s);
        hold3 <= base_s;
      end
      wrap3 <= mode_r[1];
    end
  end

  logic         d1_v;
  logic [SW-1:0] d1_q;
  logic [C-1:0]  d1_r;
  logic [C:0]    d1_p;
  logic [C-1:0]  frame4;

  ssfr_div_pipe #(.N(SW), .D(C), .P(C+1)) u_div_cnt (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .dividend(sum3), .divisor(cnt_s), .payload({wrap3, hold3}),
    .out_valid(d1_v), .quotient(d1_q), .remainder(d1_r), .out_payload(d1_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frame4 <= d1_p[C] ? d1_r : d1_p[C-1:0];
    end
  end

  logic         d2_v;
  logic [C-1:0] d2_q;
  logic [D-1:0] d2_r;
  logic [C-1:0] d2_p;

  ssfr_div_pipe #(.N(C), .D(D), .P(C)) u_div_col (
    .clk(clk), .rst(rst), .en(en), .in_valid(v4),
    .dividend(frame4), .divisor(cols_s), .payload(frame4),
    .out_valid(d2_v), .quotient(d2_q), .remainder(d2_r), .out_payload(d2_p)
  );

  logic [2*D-1:0] x5;
  logic [C+D-1:0] y5;
  logic [C-1:0]   frame5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x5     <= (2*D)'(d2_r) * (2*D)'(fw_s);
      y5     <= (C+D)'(d2_q) * (C+D)'(fh_s);
      frame5 <= d2_p;
    end
  end

  logic           in_x, in_y;
  logic [2*D:0]   xe_raw;
  logic [C+D:0]   ye_raw;
  logic [D-1:0]   xe, ye;

  always_comb begin
    in_x   = x5 < (2*D)'(image_width_r);
    in_y   = y5 < (C+D)'(image_height_r);
    xe_raw = (2*D+1)'(x5) + (2*D+1)'(fw_s);
    ye_raw = (C+D+1)'(y5) + (C+D+1)'(fh_s);
    xe     = (xe_raw < (2*D+1)'(image_width_r)) ? xe_raw[D-1:0] : image_width_r;
    ye     = (ye_raw < (C+D+1)'(image_height_r)) ? ye_raw[D-1:0] : image_height_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frame_index   <= frame5;
      grid_capacity <= cap_s;
      issue_code    <= issue_s;
      cell_width    <= cw_s;
      cell_height   <= ch_s;
      if (!empty_s && in_x && in_y) begin
        rect_x <= x5[D-1:0];
        rect_y <= y5[D-1:0];
        rect_w <= xe - x5[D-1:0];
        rect_h <= ye - y5[D-1:0];
      end else begin
        rect_x <= '0;
        rect_y <= '0;
        rect_w <= '0;
        rect_h <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (busy != '0) |-> in_stall) else $error("input taken while settling");
  a_cfg_settles: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> in_stall) else $error("no settle after write");
  a_rect_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (rect_w == '0)) |-> ((rect_x == '0) && (rect_h == '0)))
    else $error("partial empty rectangle");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall) else $error("input taken during stall");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for sprite_sheet_frame_rect_core.
// Drives ages and register writes, predicts every result and compares it field by field.
// Depends on ssfr_pkg and the block's RTL.
module tb;

  localparam int LIMIT = 300000;

  typedef struct packed {
    logic [15:0] frame;
    logic [11:0] rx, ry, rw, rh;
    ssfr_pkg::issue_t issue;
    logic [11:0] cw, ch;
    logic [23:0] cap;
  } rect_res_t;

  typedef struct packed {
    logic [11:0] cols, rows;
    logic [15:0] cnt, start, rate;
    logic [1:0]  mode;
    logic [11:0] w, h;
  } sheet_cfg_t;

  typedef struct packed {
    sheet_cfg_t  cfg;
    logic [31:0] age;
    logic        typed;
    logic [15:0] frame;
    ssfr_pkg::issue_t issue;
  } dir_row_t;

  logic clk = 0, rst;
  logic cfg_valid, cfg_ready;
  logic [ssfr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ssfr_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [ssfr_pkg::AGE_W-1:0] age;
  logic [15:0] frame_index;
  logic [11:0] rect_x, rect_y, rect_w, rect_h, cell_width, cell_height;
  logic [ssfr_pkg::ISSUE_W-1:0] issue_code;
  logic [23:0] grid_capacity;

  sheet_cfg_t sheet;
  rect_res_t  expected_rects[$];
  int errors = 0, results_seen = 0, cycles = 0;

  sprite_sheet_frame_rect_core i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic rect_res_t predict_rect(logic [31:0] a);
    longint unsigned cols, rows, cnt, base, av, sum, fr, w, h, fw, fh, x, y;
    rect_res_t r;
    r = '0;
    cols = (sheet.cols == 0) ? 1 : 64'(sheet.cols);
    rows = (sheet.rows == 0) ? 1 : 64'(sheet.rows);
    cnt = (sheet.cnt == 0) ? 1 : 64'(sheet.cnt);
    base = (64'(sheet.start) < cnt - 1) ? 64'(sheet.start) : cnt - 1;
    fr = base;
    if (sheet.mode[0]) begin
      av = a[31] ? 64'd0 : 64'(a[30:0]);
      sum = base + ((av * 64'(sheet.rate)) >> 24);
      fr = sheet.mode[1] ? sum % cnt : ((sum < cnt - 1) ? sum : cnt - 1);
    end
    w = 64'(sheet.w);
    h = 64'(sheet.h);
    if (w != 0 && h != 0) begin
      fw = (w / cols == 0) ? 1 : w / cols;
      fh = (h / rows == 0) ? 1 : h / rows;
      x = (fr % cols) * fw;
      y = (fr / cols) * fh;
      if (x < w && y < h) begin
        r.rx = 12'(x);
        r.ry = 12'(y);
        r.rw = 12'(((x + fw < w) ? x + fw : w) - x);
        r.rh = 12'(((y + fh < h) ? y + fh : h) - y);
      end
    end
    if (!sheet.mode[0] && sheet.cnt <= 1) begin
      r.cw = 12'(w);
      r.ch = 12'(h);
    end else if (w == 0 || h == 0) r.issue = ssfr_pkg::ISSUE_NO_IMAGE;
    else if (cnt > cols * rows) r.issue = ssfr_pkg::ISSUE_COUNT_GRID;
    else if (cols > w || rows > h) r.issue = ssfr_pkg::ISSUE_GRID_IMAGE;
    else if (w % cols != 0 || h % rows != 0) r.issue = ssfr_pkg::ISSUE_NOT_DIVIDES;
    else begin
      r.cw = 12'(w / cols);
      r.ch = 12'(h / rows);
    end
    r.frame = 16'(fr);
    r.cap = 24'(cols * rows);
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch in %s: got %0d, expected %0d", field, got, want);
    errors++;
  endtask

  task automatic write_reg(ssfr_pkg::cfg_idx_t idx, logic [31:0] data);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_sheet(sheet_cfg_t c);
    while (expected_rects.size() != 0) @(negedge clk);
    write_reg(ssfr_pkg::REG_GRID_COLUMNS, 32'(c.cols));
    write_reg(ssfr_pkg::REG_GRID_ROWS, 32'(c.rows));
    write_reg(ssfr_pkg::REG_FRAME_COUNT, 32'(c.cnt));
    write_reg(ssfr_pkg::REG_START_FRAME, 32'(c.start));
    write_reg(ssfr_pkg::REG_FRAME_RATE, 32'(c.rate));
    write_reg(ssfr_pkg::REG_MODE_BITS, 32'(c.mode));
    write_reg(ssfr_pkg::REG_IMAGE_WIDTH, 32'(c.w));
    write_reg(ssfr_pkg::REG_IMAGE_HEIGHT, 32'(c.h));
    cfg_valid = 0;
    sheet = c;
  endtask

  task automatic send_age(logic [31:0] a, logic typed, logic [15:0] tf,
                          ssfr_pkg::issue_t ti);
    int gap;
    rect_res_t r;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    age = a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_rect(a);
    if (typed) begin
      r.frame = tf;
      r.issue = ti;
    end
    expected_rects.push_back(r);
    @(negedge clk);
  endtask

  initial begin
    int gap;
    rect_res_t e;
    out_stall = 0;
    @(negedge clk);
    forever begin
      gap = (results_seen == 100) ? 300 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_stall = 1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_rects.size() == 0) report("unexpected item", 1, 0);
      else begin
        e = expected_rects.pop_front();
        if (frame_index !== e.frame) report("frame_index", frame_index, e.frame);
        if (rect_x !== e.rx) report("rect_x", rect_x, e.rx);
        if (rect_y !== e.ry) report("rect_y", rect_y, e.ry);
        if (rect_w !== e.rw) report("rect_w", rect_w, e.rw);
        if (rect_h !== e.rh) report("rect_h", rect_h, e.rh);
        if (issue_code !== e.issue) report("issue_code", issue_code, e.issue);
        if (cell_width !== e.cw) report("cell_width", cell_width, e.cw);
        if (cell_height !== e.ch) report("cell_height", cell_height, e.ch);
        if (grid_capacity !== e.cap) report("grid_capacity", grid_capacity, e.cap);
      end
      results_seen++;
      @(negedge clk);
    end
  end

  dir_row_t dir_tab [13] = '{
    '{'{1, 1, 1, 0, 0, 0, 0, 0}, 32'h0, 1, 0, ssfr_pkg::ISSUE_OK},
    '{'{1, 1, 1, 0, 0, 0, 0, 0}, 32'h8000_0000, 1, 0, ssfr_pkg::ISSUE_OK},
    '{'{4, 4, 16, 0, 256, 1, 0, 64}, 32'h1_0000, 1, 1, ssfr_pkg::ISSUE_NO_IMAGE},
    '{'{2, 2, 5, 0, 0, 1, 64, 64}, 32'h0, 1, 0, ssfr_pkg::ISSUE_COUNT_GRID},
    '{'{8, 1, 4, 0, 0, 1, 4, 4}, 32'h0, 1, 0, ssfr_pkg::ISSUE_GRID_IMAGE},
    '{'{3, 3, 9, 0, 0, 1, 10, 9}, 32'h0, 1, 0, ssfr_pkg::ISSUE_NOT_DIVIDES},
    '{'{4, 4, 16, 2, 0, 1, 64, 64}, 32'h0, 1, 2, ssfr_pkg::ISSUE_OK},
    '{'{4, 4, 16, 15, 256, 3, 64, 64}, 32'h1_0000, 1, 0, ssfr_pkg::ISSUE_OK},
    '{'{4, 4, 16, 15, 256, 1, 64, 64}, 32'h5_0000, 1, 15, ssfr_pkg::ISSUE_OK},
    '{'{4095, 4095, 65535, 65535, 65535, 3, 4095, 4095}, 32'h7FFF_FFFF, 0, 0,
      ssfr_pkg::ISSUE_OK},
    '{'{0, 0, 0, 0, 0, 0, 16, 16}, 32'h1234_5678, 1, 0, ssfr_pkg::ISSUE_OK},
    '{'{100, 1, 50, 49, 0, 1, 10, 10}, 32'h0, 1, 49, ssfr_pkg::ISSUE_GRID_IMAGE},
    '{'{4, 4, 16, 0, 65535, 1, 64, 64}, 32'hFFFF_FFFF, 1, 0, ssfr_pkg::ISSUE_OK}
  };

  initial begin
    sheet_cfg_t c;
    logic [31:0] a;
    rst = 1;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    age = '0;
    sheet = '{1, 1, 1, 0, 0, 0, 0, 0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    for (int i = 0; i < 13; i++) begin
      if (dir_tab[i].cfg != sheet) begin
        in_valid = 0;
        load_sheet(dir_tab[i].cfg);
      end
      send_age(dir_tab[i].age, dir_tab[i].typed, dir_tab[i].frame, dir_tab[i].issue);
    end
    in_valid = 0;
    while (expected_rects.size() != 0) @(negedge clk);
    write_reg(ssfr_pkg::cfg_idx_t'(9), $urandom);
    write_reg(ssfr_pkg::cfg_idx_t'(15), $urandom);
    cfg_valid = 0;
    send_age(32'h0002_0000, 0, 0, ssfr_pkg::ISSUE_OK);
    send_age(32'hFFF0_0000, 0, 0, ssfr_pkg::ISSUE_OK);

    for (int p = 0; p < 15; p++) begin
      c.cols = $urandom_range(1, 8);
      c.rows = $urandom_range(1, 8);
      c.w = c.cols * $urandom_range(1, 60);
      c.h = c.rows * $urandom_range(1, 60);
      c.cnt = $urandom_range(0, c.cols * c.rows);
      c.start = $urandom_range(0, c.cnt + 2);
      c.rate = $urandom;
      c.mode = $urandom;
      if ($urandom_range(0, 3) == 0) begin
        c.cols = $urandom;
        c.rows = $urandom;
        c.cnt = $urandom;
        c.start = $urandom;
        c.w = $urandom;
        c.h = $urandom;
      end
      if ($urandom_range(0, 7) == 0) c.w = 0;
      in_valid = 0;
      load_sheet(c);
      for (int k = 0; k < 50; k++) begin
        case ($urandom_range(0, 2))
          0: a = $urandom_range(0, 32'h000F_FFFF);
          1: a = $urandom_range(0, 32'h00FF_FFFF);
          default: a = $urandom;
        endcase
        send_age(a, 0, 0, ssfr_pkg::ISSUE_OK);
      end
    end
    in_valid = 0;

    while (expected_rects.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
